// ----- rtl/core/segt_pkg.sv -----
package segt_pkg;

	localparam int IDX_W      = 10;
	localparam int VAL_W      = 32;
	localparam int SUM_W      = 64;
	localparam int LEAVES_DEF = 1024;

	// beat layout on the slave side
	localparam int IN_DATA_W  = 64;
	localparam int OFS_INDEX  = 0;
	localparam int OFS_VALUE  = OFS_INDEX + IDX_W;
	localparam int OFS_LOW    = OFS_VALUE + VAL_W;
	localparam int OFS_HIGH   = OFS_LOW + IDX_W;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [IDX_W-1:0]   index;
		logic [VAL_W-1:0]   value;
		logic [IDX_W-1:0]   range_lo;
		logic [IDX_W-1:0]   range_hi;
	} item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UP_L,
		ST_UP_R,
		ST_UP_W,
		ST_Q_L,
		ST_Q_R,
		ST_Q_SH,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/segt_mem.sv -----
module segt_mem #(
	parameter int AW = 11,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/segt_ctrl.sv -----
module segt_ctrl #(
	parameter int LEAVES = segt_pkg::LEAVES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  segt_pkg::item_t             item,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [segt_pkg::SUM_W-1:0]  res_data
);
	import segt_pkg::*;

	localparam int AW = $clog2(2 * LEAVES);
	localparam int CW = $clog2(2 * LEAVES + 1);
	localparam logic [CW-1:0] LV    = CW'(LEAVES);
	localparam logic [CW-1:0] LAST  = CW'(2 * LEAVES - 1);
	localparam logic [CW-1:0] ONE   = CW'(1);
	localparam logic [31:0]   LV32  = 32'(LEAVES);
	localparam logic [31:0]   TOP32 = 32'(LEAVES - 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     l_q, l_d;      // also clear counter and write-walk node
	logic [CW-1:0]     r_q, r_d;
	logic [SUM_W-1:0]  acc_q, acc_d;
	logic              pend_q, pend_d;

	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [SUM_W-1:0]  mem_wdata;
	logic [SUM_W-1:0]  mem_rdata;

	logic [SUM_W-1:0]  add_sum;
	logic [31:0]       idx32, lo32, hi32, hic32;
	logic [CW-1:0]     r_dec, leaf_k;

	// the one shared adder
	assign add_sum = acc_q + mem_rdata;

	assign idx32  = 32'(item.index);
	assign lo32   = 32'(item.range_lo);
	assign hi32   = 32'(item.range_hi);
	assign hic32  = (hi32 >= LV32) ? TOP32 : hi32;
	assign leaf_k = CW'(idx32) + LV;
	assign r_dec  = r_q - ONE;

	segt_mem #(.AW(AW), .DW(SUM_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			l_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			l_q     <= l_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		r_q   <= r_d;
		acc_q <= acc_d;
	end

	always_comb begin
		state_d   = state_q;
		l_d       = l_q;
		r_d       = r_q;
		acc_d     = acc_q;
		pend_d    = pend_q;
		mem_we    = 1'b0;
		mem_addr  = l_q[AW-1:0];
		mem_wdata = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (l_q == LAST) begin
					state_d = ST_IDLE;
				end else begin
					l_d = l_q + ONE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (item.mode == MODE_WRITE) begin
						if (idx32 < LV32) begin
							mem_we    = 1'b1;
							mem_addr  = leaf_k[AW-1:0];
							mem_wdata = {{(SUM_W-VAL_W){item.value[VAL_W-1]}}, item.value};
							l_d       = leaf_k >> 1;
							state_d   = ST_UP_L;
						end
					end else begin
						acc_d  = '0;
						pend_d = 1'b0;
						if (lo32 <= hic32) begin
							l_d     = CW'(lo32) + LV;
							r_d     = CW'(hic32) + LV + ONE;
							state_d = ST_Q_L;
						end else begin
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_UP_L: begin
				mem_addr = {l_q[AW-2:0], 1'b0};
				state_d  = ST_UP_R;
			end
			ST_UP_R: begin
				mem_addr = {l_q[AW-2:0], 1'b1};
				acc_d    = mem_rdata;
				state_d  = ST_UP_W;
			end
			ST_UP_W: begin
				mem_we    = 1'b1;
				mem_wdata = add_sum;
				l_d       = l_q >> 1;
				state_d   = (l_q == ONE) ? ST_IDLE : ST_UP_L;
			end
			ST_Q_L: begin
				if (l_q < r_q) begin
					pend_d  = l_q[0];
					if (l_q[0]) begin
						l_d = l_q + ONE;
					end
					state_d = ST_Q_R;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_Q_R: begin
				if (pend_q) begin
					acc_d = add_sum;
				end
				pend_d   = r_q[0];
				mem_addr = r_dec[AW-1:0];
				if (r_q[0]) begin
					r_d = r_dec;
				end
				state_d = ST_Q_SH;
			end
			ST_Q_SH: begin
				if (pend_q) begin
					acc_d = add_sum;
				end
				pend_d  = 1'b0;
				l_d     = l_q >> 1;
				r_d     = r_q >> 1;
				state_d = ST_Q_L;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_data = acc_q;

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_ready) |=> state_q == ST_IDLE)
		else $error("result handed over but sequencer did not return to idle");

	a_walk_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP_L || state_q == ST_UP_R || state_q == ST_UP_W) |-> l_q != '0)
		else $error("update walk reached node zero");

	a_query_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_L || state_q == ST_Q_R || state_q == ST_Q_SH || state_q == ST_DONE)
		|-> !mem_we)
		else $error("node store written during a query");

	a_pend_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_SH && pend_q) |-> $past(state_q) == ST_Q_R)
		else $error("pending node read without an issuing step");

endmodule

// ----- rtl/core/range_sum_segment_tree.sv -----
// Range-sum segment tree over LEAVES signed 32-bit leaves, kept as 64-bit partial
// sums in a single-port node store of 2*LEAVES words. A slave beat with tuser=0
// writes a leaf and gives no result; tuser=1 asks for the sum of leaves
// range_lo..range_hi (0-based, inclusive, high clamped to the last leaf, empty
// range gives 0) and gives one 64-bit master beat. All sums wrap modulo 2^64.
// After reset the store is cleared one word a cycle, all 2*LEAVES words, with
// s_tready low. One item is taken at a time: a write stores the leaf, then for
// each ancestor reads the left and right child and writes back their sum; a query
// walks at most log2(LEAVES)+1 tree levels (read left node, read right node, shift
// both bounds), then a final compare and the hand-over. Every node access uses the
// single memory port and every sum the one shared 64-bit adder. A finished sum
// waits in the output register while the next item is already being taken; if
// that register is still full, the query stalls.
module range_sum_segment_tree #(
	parameter int LEAVES = segt_pkg::LEAVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// index[9:0], value[41:10], range_lo[51:42], range_hi[61:52], zero pad
	input  logic [63:0] s_tdata,
	// mode[0]: 0 write, 1 query
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// range_sum[63:0]
	output logic [63:0] m_tdata
);
	import segt_pkg::*;

	item_t             item;
	logic              res_valid;
	logic              res_ready;
	logic [SUM_W-1:0]  res_data;
	logic              m_tvalid_q;
	logic [SUM_W-1:0]  m_tdata_q;

	// unpack the beat
	assign item.mode     = s_tuser[0];
	assign item.index    = s_tdata[OFS_INDEX +: IDX_W];
	assign item.value    = s_tdata[OFS_VALUE +: VAL_W];
	assign item.range_lo = s_tdata[OFS_LOW +: IDX_W];
	assign item.range_hi = s_tdata[OFS_HIGH +: IDX_W];

	segt_ctrl #(.LEAVES(LEAVES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= res_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
